/* rtl/core/hbssr_pkg.sv */
// ----------------------------------------------------------------------------
// hbssr_pkg
// Shared constants, codes and types for the boost soft-start regulator core.
// ----------------------------------------------------------------------------
`default_nettype none

package hbssr_pkg;

    localparam int DUTY_W    = 10;
    localparam int ADC_W     = 10;
    localparam int GAIN_W    = 8;
    localparam int MS_W      = 16;
    localparam int SUB_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [DUTY_W-1:0] PWM_TOP  = 10'd532;
    localparam logic [DUTY_W-1:0] PWM_HALF = PWM_TOP >> 1;
    localparam logic [SUB_W-1:0]  SUB_LAST = 4'd9;

    localparam int DIV_NUM_W = DUTY_W + MS_W;
    localparam int DIV_DEN_W = MS_W;

    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_SAMPLE = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RAMP = 2'd1;
    localparam logic [1:0] PH_REG  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd3;

    localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

/* rtl/core/hbssr_div.sv */
// ----------------------------------------------------------------------------
// hbssr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hbssr_div #(
    parameter int NUM_W = hbssr_pkg::DIV_NUM_W,
    parameter int DEN_W = hbssr_pkg::DIV_DEN_W
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [NUM_W-1:0]      i_num,
    input  wire logic [DEN_W-1:0]      i_den,
    output hbssr_pkg::t_div_stat       o_stat,
    output logic      [NUM_W-1:0]      o_quo
);
    import hbssr_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W:0]   w_trial;

    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_num;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, i_den}) begin
                n_rem = DEN_W'(w_trial - {1'b0, i_den});
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[DEN_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

endmodule

`default_nettype wire

/* rtl/core/hv_boost_soft_start_regulator_core.sv */
// ----------------------------------------------------------------------------
// hv_boost_soft_start_regulator_core
// Soft-start ramp and proportional regulation of a boost PWM compare value.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) takes one word per event: a start,
// a millisecond tick or an ADC sample (i_mode, i_sample). Each word gives one
// result word on the output channel (o_out_valid / i_out_ready) carrying the
// duty, ready flag, phase and timeout flag after the event.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data), to be
// written by the user while no word is in flight; the core does not enforce it.
// Each word passes EXEC and DONE before its result enters the output register;
// a sample once ready is set also passes ADJ, and every tenth ramp tick passes
// DIVGO and DIVW, where PWM_TOP times the elapsed milliseconds is divided by
// the ramp length in a restoring divider, one bit per cycle (26 quotient bits).
// One word is in the core at a time; o_in_ready is low while it is worked on.
// A result waits in the output register while the receiver stalls; the next
// word may be accepted meanwhile but its result holds until the register
// frees.
// Reset puts the core idle with duty zero and registers at their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module hv_boost_soft_start_regulator_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [1:0]                        i_mode,
    input  wire logic [hbssr_pkg::ADC_W-1:0]       i_sample,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [hbssr_pkg::DUTY_W-1:0]      o_duty,
    output logic                                   o_is_ready,
    output logic      [1:0]                        o_phase_now,
    output logic                                   o_timed_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [hbssr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [hbssr_pkg::CFG_W-1:0]       i_cfg_data
);
    import hbssr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_DIVGO = 3'd2;
    localparam logic [2:0] S_DIVW  = 3'd3;
    localparam logic [2:0] S_ADJ   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam int PROD_W = ADC_W + 1 + GAIN_W;
    localparam int ADJ_W  = PROD_W - 4;
    localparam int SUM_W  = ADJ_W + 1;

    logic [ADC_W-1:0]     r_target;
    logic [GAIN_W-1:0]    r_kp;
    logic [MS_W-1:0]      r_ramp;
    logic [MS_W-1:0]      r_tmo;

    logic [2:0]           r_state, n_state;
    logic [1:0]           r_phase, n_phase;
    logic [DUTY_W-1:0]    r_duty, n_duty;
    logic                 r_rdy, n_rdy;
    logic [MS_W-1:0]      r_elapsed, n_elapsed;
    logic [SUB_W-1:0]     r_sub, n_sub;
    logic                 r_tout, n_tout;
    logic [1:0]           r_mode;
    logic [ADC_W-1:0]     r_sample;
    logic [DIV_NUM_W-1:0] r_ramp_prod, n_ramp_prod;
    logic signed [PROD_W-1:0] r_reg_prod, n_reg_prod;
    logic                 r_out_valid, n_out_valid;
    logic [DUTY_W-1:0]    r_out_duty;
    logic                 r_out_rdy;
    logic [1:0]           r_out_phase;
    logic                 r_out_tout;

    logic                 w_accept;
    logic                 w_div_start;
    t_div_stat            w_div_stat;
    logic [DIV_NUM_W-1:0] w_quo;
    logic [MS_W-1:0]      w_inc;
    logic signed [ADC_W:0]    w_err;
    logic signed [PROD_W-1:0] w_prod_rnd;
    logic signed [ADJ_W-1:0]  w_adj;
    logic signed [SUM_W-1:0]  w_sum;
    logic                 w_load_out;

    assign w_accept    = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_div_start = (r_state == S_DIVGO);
    assign w_load_out  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    hbssr_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_ramp_prod),
        .i_den   (r_ramp),
        .o_stat  (w_div_stat),
        .o_quo   (w_quo)
    );

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_duty      = r_duty;
        n_rdy       = r_rdy;
        n_elapsed   = r_elapsed;
        n_sub       = r_sub;
        n_tout      = r_tout;
        n_ramp_prod = r_ramp_prod;
        n_reg_prod  = r_reg_prod;
        n_out_valid = r_out_valid;
        w_inc       = r_elapsed + 1'b1;
        w_err       = $signed({1'b0, r_target}) - $signed({1'b0, r_sample});
        w_prod_rnd  = r_reg_prod + (r_reg_prod < 0 ? PROD_W'(15) : PROD_W'(0));
        w_adj       = ADJ_W'(w_prod_rnd >>> 4);
        w_sum       = $signed({{(SUM_W - DUTY_W){1'b0}}, r_duty}) + SUM_W'(w_adj);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_mode)
                    MODE_START: begin
                        n_duty    = '0;
                        n_rdy     = 1'b0;
                        n_tout    = 1'b0;
                        n_elapsed = '0;
                        n_sub     = '0;
                        n_phase   = PH_RAMP;
                        if (r_ramp == '0) begin
                            n_duty  = PWM_HALF;
                            n_phase = PH_REG;
                            n_tout  = (r_tmo == '0);
                        end
                    end
                    MODE_TICK: begin
                        if (r_phase == PH_RAMP) begin
                            n_elapsed = w_inc;
                            if (w_inc >= r_ramp || w_inc == '0) begin
                                n_duty    = PWM_HALF;
                                n_phase   = PH_REG;
                                n_elapsed = '0;
                                if (r_tmo == '0 && !r_rdy) begin
                                    n_tout = 1'b1;
                                end
                            end else if (r_sub == SUB_LAST) begin
                                n_sub       = '0;
                                n_ramp_prod = DIV_NUM_W'(PWM_TOP) * DIV_NUM_W'(w_inc);
                                n_state     = S_DIVGO;
                            end else begin
                                n_sub = r_sub + 1'b1;
                            end
                        end else if (r_phase == PH_REG) begin
                            if (!r_rdy && !r_tout) begin
                                if (r_elapsed != MS_MAX) begin
                                    n_elapsed = w_inc;
                                end
                                if (n_elapsed >= r_tmo) begin
                                    n_tout = 1'b1;
                                end
                            end
                        end
                    end
                    MODE_SAMPLE: begin
                        if (r_phase == PH_REG) begin
                            if (r_rdy || (r_duty != '0 && r_sample >= r_target)) begin
                                n_rdy      = 1'b1;
                                n_reg_prod = PROD_W'(w_err * $signed({1'b0, r_kp}));
                                n_state    = S_ADJ;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_DIVGO: begin
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (w_div_stat.done) begin
                    n_duty  = (w_quo > DIV_NUM_W'(PWM_TOP)) ? PWM_TOP : w_quo[DUTY_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_ADJ: begin
                if (w_sum < 0) begin
                    n_duty = '0;
                end else if (w_sum > $signed({{(SUM_W - DUTY_W){1'b0}}, PWM_TOP})) begin
                    n_duty = PWM_TOP;
                end else begin
                    n_duty = w_sum[DUTY_W-1:0];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= 10'd512;
            r_kp        <= 8'd16;
            r_ramp      <= 16'd500;
            r_tmo       <= 16'd1000;
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_duty      <= '0;
            r_rdy       <= 1'b0;
            r_elapsed   <= '0;
            r_sub       <= '0;
            r_tout      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TARGET:  r_target <= i_cfg_data[ADC_W-1:0];
                    REG_GAIN:    r_kp     <= i_cfg_data[GAIN_W-1:0];
                    REG_RAMP:    r_ramp   <= i_cfg_data[MS_W-1:0];
                    REG_TIMEOUT: r_tmo    <= i_cfg_data[MS_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_duty      <= n_duty;
            r_rdy       <= n_rdy;
            r_elapsed   <= n_elapsed;
            r_sub       <= n_sub;
            r_tout      <= n_tout;
            r_out_valid <= n_out_valid;
        end
        if (w_accept) begin
            r_mode   <= i_mode;
            r_sample <= i_sample;
        end
        r_ramp_prod <= n_ramp_prod;
        r_reg_prod  <= n_reg_prod;
        if (w_load_out) begin
            r_out_duty  <= r_duty;
            r_out_rdy   <= r_rdy;
            r_out_phase <= r_phase;
            r_out_tout  <= r_tout;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_duty      = r_out_duty;
    assign o_is_ready  = r_out_rdy;
    assign o_phase_now = r_out_phase;
    assign o_timed_out = r_out_tout;

endmodule

`default_nettype wire

/* test/hbssr_status_checker.sv */
// ----------------------------------------------------------------------------
// hbssr_status_checker
// Follows both channels and the register port of the soft-start regulator
// core. Keeps its own copy of the regulator state, works out the status
// word that each accepted event should return, and compares every returned
// word field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module hbssr_status_checker
    import hbssr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [1:0]           i_mode,
    input  logic [ADC_W-1:0]     i_sample,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [DUTY_W-1:0]    i_duty,
    input  logic                 i_is_ready,
    input  logic [1:0]           i_phase_now,
    input  logic                 i_timed_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_mismatches,
    output int                   o_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              ready;
        logic [1:0]        phase;
        logic              timeout;
    } reg_status_t;

    localparam int KP_SCALE = 16;

    logic [ADC_W-1:0]  target_lvl;
    logic [GAIN_W-1:0] kp;
    logic [MS_W-1:0]   ramp_len;
    logic [MS_W-1:0]   ready_wait;

    logic [1:0]        phase_q;
    logic [DUTY_W-1:0] duty_q;
    logic              ready_q;
    logic              timeout_q;
    logic [MS_W-1:0]   ms_q;
    logic [SUB_W-1:0]  tenth_q;

    reg_status_t status_q[$];
    int          mismatches = 0;
    int          in_flight  = 0;

    assign o_mismatches = mismatches;
    assign o_in_flight  = in_flight;

    task automatic report(input string what, input int got, input int want);
        mismatches++;
        $display("%0t checker: %s mismatch, got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic void begin_regulation();
        duty_q  = PWM_HALF;
        phase_q = PH_REG;
        ms_q    = '0;
        if (ready_wait == '0 && !ready_q)
            timeout_q = 1'b1;
    endfunction

    function automatic reg_status_t step_regulator(input logic [1:0] mode,
                                                   input logic [ADC_W-1:0] adc);
        reg_status_t s;
        int unsigned scaled;
        int          err;
        int          nd;
        case (mode)
            MODE_START: begin
                duty_q    = '0;
                ready_q   = 1'b0;
                timeout_q = 1'b0;
                ms_q      = '0;
                tenth_q   = '0;
                phase_q   = PH_RAMP;
                if (ramp_len == '0)
                    begin_regulation();
            end
            MODE_TICK: begin
                if (phase_q == PH_RAMP) begin
                    ms_q = ms_q + 1'b1;
                    if (ms_q >= ramp_len || ms_q == '0) begin
                        begin_regulation();
                    end else if (tenth_q >= SUB_LAST) begin
                        tenth_q = '0;
                        scaled  = (int'(PWM_TOP) * int'(ms_q)) / int'(ramp_len);
                        duty_q  = (scaled > PWM_TOP) ? PWM_TOP : scaled[DUTY_W-1:0];
                    end else begin
                        tenth_q = tenth_q + 1'b1;
                    end
                end else if (phase_q == PH_REG && !ready_q && !timeout_q) begin
                    if (ms_q != MS_MAX)
                        ms_q = ms_q + 1'b1;
                    if (ms_q >= ready_wait)
                        timeout_q = 1'b1;
                end
            end
            MODE_SAMPLE: begin
                if (phase_q == PH_REG) begin
                    if (!ready_q && duty_q != '0 && adc >= target_lvl)
                        ready_q = 1'b1;
                    if (ready_q) begin
                        err = int'(target_lvl) - int'(adc);
                        nd  = int'(duty_q) + (err * int'(kp)) / KP_SCALE;
                        if (nd < 0)
                            nd = 0;
                        if (nd > int'(PWM_TOP))
                            nd = int'(PWM_TOP);
                        duty_q = nd[DUTY_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        s.duty    = duty_q;
        s.ready   = ready_q;
        s.phase   = phase_q;
        s.timeout = timeout_q;
        return s;
    endfunction

    always @(posedge i_clk) begin
        reg_status_t want;
        if (!i_rst_n) begin
            target_lvl = 10'd512;
            kp         = 8'd16;
            ramp_len   = 16'd500;
            ready_wait = 16'd1000;
            phase_q    = PH_IDLE;
            duty_q     = '0;
            ready_q    = 1'b0;
            timeout_q  = 1'b0;
            ms_q       = '0;
            tenth_q    = '0;
            status_q.delete();
            in_flight <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TARGET:  target_lvl = i_cfg_data[ADC_W-1:0];
                    REG_GAIN:    kp         = i_cfg_data[GAIN_W-1:0];
                    REG_RAMP:    ramp_len   = i_cfg_data[MS_W-1:0];
                    REG_TIMEOUT: ready_wait = i_cfg_data[MS_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (status_q.size() == 0) begin
                    report("status word with nothing outstanding", 1, 0);
                end else begin
                    want = status_q.pop_front();
                    if (i_duty !== want.duty)
                        report("duty", i_duty, want.duty);
                    if (i_is_ready !== want.ready)
                        report("is_ready", i_is_ready, want.ready);
                    if (i_phase_now !== want.phase)
                        report("phase_now", i_phase_now, want.phase);
                    if (i_timed_out !== want.timeout)
                        report("timed_out", i_timed_out, want.timeout);
                end
            end
            if (i_in_valid && i_in_ready)
                status_q.push_back(step_regulator(i_mode, i_sample));
            in_flight <= status_q.size();
        end
    end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the soft-start regulator core with starts, millisecond ticks and
// ADC samples: a directed opening over the corner cases, then randomised
// start/ramp/regulation sequences under many register settings, with bursty
// input, a stalling receiver and one long receiver hold-off. The checker
// instance predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hbssr_pkg::*;

    localparam logic [1:0] MODE_SPARE   = 2'd3;
    localparam int         RANDOM_WORDS = 1550;
    localparam int         HOLD_AT      = 400;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         TAIL_CYCLES  = 40;
    localparam int         LIMIT_CYCLES = 600000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [1:0]           i_mode;
    logic [ADC_W-1:0]     i_sample;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [DUTY_W-1:0]    o_duty;
    logic                 o_is_ready;
    logic [1:0]           o_phase_now;
    logic                 o_timed_out;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    int               fail_count;
    int               in_flight;
    int               words_sent;
    int               burst_left;
    bit               gaps_on;
    bit               hold_req;
    logic [ADC_W-1:0] cur_target;
    logic [MS_W-1:0]  cur_ramp;

    hv_boost_soft_start_regulator_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_duty      (o_duty),
        .o_is_ready  (o_is_ready),
        .o_phase_now (o_phase_now),
        .o_timed_out (o_timed_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    hbssr_status_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_sample     (i_sample),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_duty       (o_duty),
        .i_is_ready   (o_is_ready),
        .i_phase_now  (o_phase_now),
        .i_timed_out  (o_timed_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (fail_count),
        .o_in_flight  (in_flight)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic offer_word(input logic [1:0] mode, input logic [ADC_W-1:0] adc);
        int gap;
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_sample   <= adc;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        words_sent++;
        if (words_sent == HOLD_AT)
            hold_req = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (in_flight != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_registers(input logic [CFG_W-1:0] tgt, input logic [CFG_W-1:0] gain,
                                  input logic [CFG_W-1:0] ramp, input logic [CFG_W-1:0] hold);
        write_reg(REG_TARGET, tgt);
        write_reg(REG_GAIN, gain);
        write_reg(REG_RAMP, ramp);
        write_reg(REG_TIMEOUT, hold);
        cur_target = tgt[ADC_W-1:0];
        cur_ramp   = ramp;
    endtask

    task automatic run_sequence();
        logic [CFG_W-1:0] tgt;
        logic [CFG_W-1:0] gain;
        logic [CFG_W-1:0] ramp;
        logic [CFG_W-1:0] hold;
        int               n_ramp;
        int               n_reg;
        int               r;
        int               v;
        settle();
        case ($urandom_range(0, 9))
            0:       tgt = 16'h0000;
            1:       tgt = 16'h03FF;
            default: tgt = $urandom_range(0, 1023);
        endcase
        if ($urandom_range(0, 4) == 0)
            tgt[CFG_W-1:ADC_W] = $urandom;
        case ($urandom_range(0, 9))
            0:       gain = 16'h0000;
            1:       gain = 16'h00FF;
            default: gain = $urandom_range(0, 255);
        endcase
        if ($urandom_range(0, 4) == 0)
            gain[CFG_W-1:GAIN_W] = $urandom;
        case ($urandom_range(0, 19))
            0:       ramp = 16'h0000;
            1:       ramp = 16'hFFFF;
            2:       ramp = $urandom_range(0, 65535);
            3:       ramp = $urandom_range(100, 250);
            default: ramp = $urandom_range(1, 40);
        endcase
        case ($urandom_range(0, 9))
            0:       hold = 16'h0000;
            1:       hold = 16'hFFFF;
            2:       hold = $urandom_range(0, 65535);
            default: hold = $urandom_range(0, 15);
        endcase
        load_registers(tgt, gain, ramp, hold);
        gaps_on = ($urandom_range(0, 3) != 0);

        offer_word(MODE_START, $urandom_range(0, 1023));
        n_ramp = (cur_ramp <= 300) ? int'(cur_ramp) : 25;
        for (int k = 0; k < n_ramp; k++) begin
            r = $urandom_range(0, 99);
            if (r < 6)
                offer_word(MODE_SAMPLE, $urandom_range(0, 1023));
            else if (r < 8)
                offer_word(MODE_SPARE, $urandom_range(0, 1023));
            else if (r == 8)
                offer_word(MODE_START, $urandom_range(0, 1023));
            offer_word(MODE_TICK, $urandom_range(0, 1023));
        end

        n_reg = $urandom_range(8, 40);
        for (int k = 0; k < n_reg; k++) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                v = int'(cur_target) + int'($urandom_range(0, 40)) - 20;
                if (v < 0)
                    v = 0;
                if (v > 1023)
                    v = 1023;
                offer_word(MODE_SAMPLE, v[ADC_W-1:0]);
            end else if (r < 70) begin
                offer_word(MODE_SAMPLE, $urandom_range(0, 1023));
            end else if (r < 95) begin
                offer_word(MODE_TICK, $urandom_range(0, 1023));
            end else if (r < 98) begin
                offer_word(MODE_SPARE, $urandom_range(0, 1023));
            end else begin
                offer_word(MODE_START, $urandom_range(0, 1023));
            end
        end
    endtask

    initial begin
        int opening;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_mode     <= MODE_START;
        i_sample   <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_TARGET;
        i_cfg_data <= '0;
        words_sent = 0;
        burst_left = 1;
        gaps_on    = 1'b0;
        hold_req   = 1'b0;
        cur_target = 10'd512;
        cur_ramp   = 16'd500;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle, unused mode, sample during ramp, first ramp division
        offer_word(MODE_TICK, '0);
        offer_word(MODE_SAMPLE, '1);
        offer_word(MODE_SPARE, '1);
        offer_word(MODE_START, '0);
        offer_word(MODE_SAMPLE, 10'd512);
        repeat (10) offer_word(MODE_TICK, '0);

        // zero-length ramp with no wait, late ready, clamp at the top
        settle();
        load_registers(16'h03FF, 16'h00FF, 16'h0000, 16'h0000);
        offer_word(MODE_START, '0);
        offer_word(MODE_SAMPLE, '1);
        offer_word(MODE_SAMPLE, '0);

        // one-tick ramp, ready at zero target, clamp at zero, ticks after ready
        settle();
        load_registers(16'h0000, 16'h00FF, 16'h0001, 16'hFFFF);
        offer_word(MODE_START, '0);
        offer_word(MODE_TICK, '0);
        offer_word(MODE_SAMPLE, '0);
        offer_word(MODE_SAMPLE, '1);
        offer_word(MODE_TICK, '0);

        // timeout on the first tick after the ramp, then a small negative error truncated to zero
        settle();
        load_registers(16'd600, 16'd1, 16'd1, 16'd1);
        offer_word(MODE_START, '0);
        offer_word(MODE_TICK, '0);
        offer_word(MODE_TICK, '0);
        offer_word(MODE_SAMPLE, 10'd601);

        opening = words_sent;
        while (words_sent - opening < RANDOM_WORDS)
            run_sequence();

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && in_flight == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial begin
        int style;
        int left;
        bit hold_done;
        i_out_ready <= 1'b0;
        style     = 0;
        left      = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge i_clk);
                hold_done = 1'b1;
                i_out_ready <= 1'b1;
            end else begin
                if (left == 0) begin
                    style = $urandom_range(0, 3);
                    left  = $urandom_range(16, 160);
                end
                left--;
                case (style)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= $urandom_range(0, 1);
                    2:       i_out_ready <= ($urandom_range(0, 5) == 0);
                    default: i_out_ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench: FAIL");
        $finish;
    end

endmodule

/* hv_boost_soft_start_regulator_core.f */
rtl/core/hbssr_pkg.sv
rtl/core/hbssr_div.sv
rtl/core/hv_boost_soft_start_regulator_core.sv
test/hbssr_status_checker.sv
test/testbench.sv
